[rtl/cdc_pkg.sv]
// Package for the common divisor counter: widths, limits and shared types.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none
package cdc_pkg;
  localparam int VALUE_BITS  = 20;
  localparam int PRIME_LIMIT = 1024;
  localparam int COUNT_BITS  = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = 1;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  // Classified job handed from the GCD front to the factoring back.
  typedef struct packed {
    value_t gcd;
    logic   trivial;
  } job_t;
endpackage
`default_nettype wire

[rtl/cdc_if.sv]
// Valid/ready channel interfaces for operands and results.
// Depends on cdc_pkg.
`default_nettype none
interface cdc_in_if;
  logic             valid;
  logic             ready;
  cdc_pkg::value_t  value_a;
  cdc_pkg::value_t  value_b;
  modport source (output valid, output value_a, output value_b, input ready);
  modport sink (input valid, input value_a, input value_b, output ready);
endinterface

interface cdc_out_if;
  logic            valid;
  logic            ready;
  cdc_pkg::count_t divisor_count;
  modport source (output valid, output divisor_count, input ready);
  modport sink (input valid, input divisor_count, output ready);
endinterface
`default_nettype wire

[rtl/cdc_divmod.sv]
// Restoring divider, one quotient bit per cycle; GCD and factoring each use their own instance.
// Depends on cdc_pkg.
`default_nettype none
module cdc_divmod (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire cdc_pkg::value_t  dividend,
  input  wire cdc_pkg::value_t  divisor,
  output logic                  done,
  output cdc_pkg::value_t       quotient,
  output cdc_pkg::value_t       remainder
);
  localparam int CBITS = $clog2(cdc_pkg::VALUE_BITS + 1);
  logic             busy;
  logic [CBITS-1:0] cnt;
  cdc_pkg::value_t  dvs;
  logic [cdc_pkg::VALUE_BITS:0] trial;

  assign trial = {remainder, quotient[cdc_pkg::VALUE_BITS-1]}
                 - {1'b0, dvs};

  // Shift one bit of the dividend into the partial remainder per cycle
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy      <= 1'b1;
      cnt       <= CBITS'(cdc_pkg::VALUE_BITS);
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (busy) begin
      if (!trial[cdc_pkg::VALUE_BITS]) begin
        remainder <= trial[cdc_pkg::VALUE_BITS-1:0];
        quotient  <= {quotient[cdc_pkg::VALUE_BITS-2:0], 1'b1};
      end else begin
        remainder <= {remainder[cdc_pkg::VALUE_BITS-2:0],
                      quotient[cdc_pkg::VALUE_BITS-1]};
        quotient  <= {quotient[cdc_pkg::VALUE_BITS-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CBITS'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

[rtl/cdc_front.sv]
// Front end: accepts operands, runs Euclid's GCD and classifies the job.
// Depends on cdc_pkg, cdc_if and cdc_divmod.
`default_nettype none
module cdc_front (
  input  wire logic        clk,
  input  wire logic        rst,
  cdc_in_if.sink           in_ch,
  output logic             job_valid,
  input  wire logic        job_ready,
  output cdc_pkg::job_t    job
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_STEP = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]      state;
  cdc_pkg::value_t x, y, q, r;
  logic            start, done;

  cdc_divmod u_div (.clk, .rst, .start, .dividend(x), .divisor(y),
                    .done, .quotient(q), .remainder(r));

  assign in_ch.ready = (state == S_IDLE);
  assign start       = (state == S_STEP) && (y != '0);
  assign job_valid   = (state == S_OUT);
  assign job.gcd     = x;
  assign job.trivial = (x[cdc_pkg::VALUE_BITS-1:1] == '0);

  // Iterate x,y <- y, x mod y until y is zero
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (in_ch.valid) begin
          x     <= in_ch.value_a;
          y     <= in_ch.value_b;
          state <= S_STEP;
        end
        S_STEP: state <= (y == '0) ? S_OUT : S_WAIT;
        S_WAIT: if (done) begin
          x     <= y;
          y     <= r;
          state <= S_STEP;
        end
        S_OUT: if (job_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[rtl/cdc_queue.sv]
// Two-entry job queue between the GCD front and the factoring back.
// Depends on cdc_pkg.
`default_nettype none
module cdc_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire cdc_pkg::job_t push_job,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output cdc_pkg::job_t      pop_job
);
  cdc_pkg::job_t                 slots [cdc_pkg::QUEUE_DEPTH];
  logic [cdc_pkg::QPTR_BITS-1:0] wptr, rptr;
  logic [cdc_pkg::QPTR_BITS:0]   fill;
  logic                          push, pop;

  assign push_ready = (fill != (cdc_pkg::QPTR_BITS+1)'(cdc_pkg::QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_job    = slots[rptr];
  assign push = push_valid && push_ready;
  assign pop  = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_job;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      fill <= fill + (cdc_pkg::QPTR_BITS+1)'(push) - (cdc_pkg::QPTR_BITS+1)'(pop);
    end
  end
endmodule
`default_nettype wire

[rtl/cdc_back.sv]
// Back end: trial division of the GCD by 2 and odd candidates, product of
// (exponent + 1) terms, result register. Depends on cdc_pkg, cdc_if, cdc_divmod.
`default_nettype none
module cdc_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          job_valid,
  output logic               job_ready,
  input  wire cdc_pkg::job_t job,
  cdc_out_if.source          out_ch
);
  localparam int DBITS = $clog2(cdc_pkg::PRIME_LIMIT + 1);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TWO   = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_TAIL  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]              state;
  cdc_pkg::value_t         g, q, r;
  logic [DBITS-1:0]        d;
  logic [cdc_pkg::COUNT_BITS-1:0] e;
  logic [cdc_pkg::COUNT_BITS-1:0] res;
  logic [2*cdc_pkg::COUNT_BITS-1:0] prod;
  logic [2*DBITS-1:0]      dsq;
  logic                    start, done;

  cdc_divmod u_div (.clk, .rst, .start, .dividend(g),
                    .divisor(cdc_pkg::VALUE_BITS'(d)), .done,
                    .quotient(q), .remainder(r));

  assign dsq       = d * d;
  assign prod      = res * (e + 1'b1);
  // Keep dividing by the current candidate once it has divided at least once
  assign start     = (state == S_CHECK) && ((e != '0) ||
                     ((d < DBITS'(cdc_pkg::PRIME_LIMIT)) &&
                      ({{cdc_pkg::VALUE_BITS{1'b0}}, dsq} <=
                       (2*DBITS+cdc_pkg::VALUE_BITS)'(g))));
  assign job_ready = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.divisor_count = res;

  // Sequence factoring: strip twos, then each odd candidate by division, then count a leftover factor
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (job_valid) begin
          g     <= job.gcd;
          res   <= 8'd1;
          e     <= '0;
          d     <= DBITS'(3);
          state <= job.trivial ? S_OUT : S_TWO;
        end
        S_TWO: if (!g[0]) begin
          g <= g >> 1;
          e <= e + 1'b1;
        end else begin
          res   <= (prod > 16'd255) ? 8'd255 : prod[7:0];
          e     <= '0;
          state <= S_CHECK;
        end
        S_CHECK: state <= start ? S_WAIT : S_TAIL;
        S_WAIT: if (done) begin
          if (r == '0) begin
            g     <= q;
            e     <= e + 1'b1;
            state <= S_CHECK;
          end else begin
            res   <= (prod > 16'd255) ? 8'd255 : prod[7:0];
            e     <= '0;
            d     <= d + DBITS'(2);
            state <= S_CHECK;
          end
        end
        S_TAIL: begin
          if (g > cdc_pkg::VALUE_BITS'(1)) begin
            res <= (res[7]) ? 8'd255 : {res[6:0], 1'b0};
          end
          state <= S_OUT;
        end
        S_OUT: if (out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[rtl/common_divisor_counter.sv]
// Top level of the common divisor counter: front, queue and back joined.
// Depends on cdc_pkg, cdc_if, cdc_front, cdc_queue and cdc_back.
//
// Usage: operands value_a and value_b arrive on in_ch (valid/ready); each
// beat yields exactly one beat on out_ch carrying divisor_count, the number
// of positive integers dividing both operands (1 when the GCD is 0 or 1).
// The front runs Euclid's GCD on a bit-serial divider, one division per
// remainder step (up to ~30 steps). The back strips twos one per cycle,
// then tries each odd candidate d below 1024 with d*d <= residue, one
// division per try; a full pass covers 511 candidates.
// Throughput is set by the back end's divider. A two-beat queue lets the
// front take and reduce the next operands while the back is still factoring.
// Reset (rst, synchronous) empties the queue and returns both ends to idle.
// When the receiver stalls, the result holds on out_ch and the back stops;
// the front fills the queue and then deasserts ready.
`default_nettype none
module common_divisor_counter (
  input wire logic  clk,
  input wire logic  rst,
  cdc_in_if.sink    in_ch,
  cdc_out_if.source out_ch
);
  logic          f_valid, f_ready, b_valid, b_ready;
  cdc_pkg::job_t f_job, b_job;

  cdc_front u_front (.clk, .rst, .in_ch, .job_valid(f_valid),
                     .job_ready(f_ready), .job(f_job));
  cdc_queue u_queue (.clk, .rst, .push_valid(f_valid), .push_ready(f_ready),
                     .push_job(f_job), .pop_valid(b_valid),
                     .pop_ready(b_ready), .pop_job(b_job));
  cdc_back  u_back  (.clk, .rst, .job_valid(b_valid), .job_ready(b_ready),
                     .job(b_job), .out_ch);

`ifndef SYNTHESIS
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.divisor_count != '0) else $error("zero count");
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> $stable(out_ch.divisor_count))
    else $error("result changed under stall");
  a_trivial_one: assert property (@(posedge clk) disable iff (rst)
    b_valid && b_ready && b_job.trivial |=> out_ch.valid && out_ch.divisor_count == 8'd1)
    else $error("trivial gcd count");
`endif
endmodule
`default_nettype wire
